>>> rtl/aes_encrypt_ctr_engine_top_macros.svh
// Assertion macros shared by the AES engine RTL.
// No dependencies.
`ifndef AES_ENCRYPT_CTR_ENGINE_TOP_MACROS_SVH
`define AES_ENCRYPT_CTR_ENGINE_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/aes_ctr_pkg.sv
// Package for the AES encrypt/CTR engine: constants, types, S-box and round functions.
// No dependencies.
package aes_ctr_pkg;

  localparam int ROUND_KEY_WORDS_DEF = 60;
  localparam int RK_WORDS_128 = 44;
  localparam int NR_128 = 10;
  localparam int NR_256 = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte k sits at bits 127-8k; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (c * 4 + r) -: 8] = sbox(s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, t;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 32 * c -: 8] = a0 ^ t ^ xt(a0 ^ a1);
      o[119 - 32 * c -: 8] = a1 ^ t ^ xt(a1 ^ a2);
      o[111 - 32 * c -: 8] = a2 ^ t ^ xt(a2 ^ a3);
      o[103 - 32 * c -: 8] = a3 ^ t ^ xt(a3 ^ a0);
    end
    return o;
  endfunction

endpackage

>>> rtl/aes_ctr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module aes_ctr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/aes_encrypt_ctr_engine_top.sv
// Top level of the AES-128/256 encrypt and CTR engine.
// Depends on aes_ctr_pkg, aes_ctr_ram and aes_encrypt_ctr_engine_top_macros.svh.
//
// Usage: registers are written through cfg_we/cfg_index/cfg_data while idle.
// A write to a key word or to key_size starts a key expansion that writes
// the round keys into a 60 x 32 RAM, one word per cycle;
// no beat is accepted until it finishes.
// The slave channel carries one 128-bit block, byte count and start flag per
// beat; the master channel returns one 128-bit result per beat.
// Each block is worked one column at a time, one round key word per RAM read;
// the single RAM read port sets this pace.
// One block is in work at a time; s_tready is high only when idle.
// The result waits in the output register while m_tready is low, and the
// engine holds until it is taken.
// Reset clears the configuration registers, the counter and the control state; the round
// key RAM holds no defined value until the first key write.
module aes_encrypt_ctr_engine_top
  import aes_ctr_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = ROUND_KEY_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [135:0]          s_tdata,  // data_high, data_low, byte_count, start_req, pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata   // result_high, result_low
);

  `include "aes_encrypt_ctr_engine_top_macros.svh"

  localparam int AW = $clog2(ROUND_KEY_WORDS);

  logic [63:0] key0, key1, key2, key3, iv_high, iv_low;
  logic        key_size, cipher_mode;
  logic [63:0] ctr_high, ctr_low;
  state_t      state, state_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] raddr;
  logic [31:0] rdata;
  logic        we;
  logic [31:0] wdata;
  logic [31:0] hist [8];
  logic [127:0] st, acc;
  logic [3:0]  rnd;
  logic [1:0]  col;
  logic        first;
  logic [127:0] data;
  logic [4:0]  cnt;
  logic        ctr_blk;
  logic [127:0] result;
  logic        out_valid;
  logic        key_write;

  assign key_write = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                     cfg_index == REG_KEY2 || cfg_index == REG_KEY3 ||
                     cfg_index == REG_KEY_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0;
      iv_high <= '0; iv_low <= '0; key_size <= 1'b0; cipher_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key0 <= cfg_data;
        REG_KEY1: key1 <= cfg_data;
        REG_KEY2: key2 <= cfg_data;
        REG_KEY3: key3 <= cfg_data;
        REG_IV_HIGH: iv_high <= cfg_data;
        REG_IV_LOW: iv_low <= cfg_data;
        REG_KEY_SIZE: key_size <= cfg_data[0];
        REG_CIPHER_MODE: cipher_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Key expansion word generator: hist holds the last eight words, newest at 0.
  logic [2:0]  nk_m1;
  logic [31:0] prev, back, t;
  logic [AW-1:0] total;
  logic [5:0]  i6;
  logic [63:0] kw;
  always_comb begin
    nk_m1 = key_size ? 3'd7 : 3'd3;
    total = key_size ? AW'(ROUND_KEY_WORDS) : AW'(RK_WORDS_128);
    i6 = 6'(idx);
    prev = hist[0];
    back = hist[nk_m1];
    t = prev;
    if (key_size) begin
      if (i6[2:0] == 3'd0) begin
        t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(4'(i6 >> 3)), 24'h0};
      end else if (i6[2:0] == 3'd4) begin
        t = sub_word(prev);
      end
    end else if (i6[1:0] == 2'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(4'(i6 >> 2)), 24'h0};
    end
    case (i6[2:1])
      2'd0: kw = key0;
      2'd1: kw = key1;
      2'd2: kw = key2;
      default: kw = key3;
    endcase
    if (i6 <= 6'(nk_m1)) begin
      wdata = i6[0] ? kw[31:0] : kw[63:32];
    end else begin
      wdata = back ^ t;
    end
  end

  assign we = (state == ST_EXPAND);

  always_ff @(posedge clk) begin
    if (we) begin
      hist[0] <= wdata;
      for (int k = 1; k < 8; k++) begin
        hist[k] <= hist[k - 1];
      end
    end
  end

  logic [3:0] nr;
  assign nr = key_size ? 4'(NR_256) : 4'(NR_128);
  assign raddr = AW'({rnd, col});

  aes_ctr_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_WORDS)) u_rk_ram (
    .clk(clk), .we(we), .waddr(idx), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic acc_in, out_take;
  assign acc_in = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  // Round datapath: the read issued for word (rnd,col) returns in the next cycle.
  logic [127:0] pre, key_added, blk_in, ks, masked;
  logic [127:0] mask;
  logic [4:0] n;
  logic [3:0] rnd_d;
  logic [1:0] col_d;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (key_write) state_next = ST_EXPAND;
        else if (acc_in) state_next = ST_LOAD;
      end
      ST_EXPAND: if (idx == total - AW'(1)) state_next = ST_IDLE;
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (rnd_d == nr && col_d == 2'd3 && !first) state_next = ST_OUT;
      ST_OUT: if (out_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE) && !key_write;
    m_tvalid = out_valid;
    m_tdata = {result[63:0], result[127:64]};
  end

  always_comb begin
    pre = (rnd_d == 4'd0) ? st : ((rnd_d == nr) ? sub_shift(st) : mix(sub_shift(st)));
    key_added = acc;
    key_added[127 - 32 * col_d -: 32] = pre[127 - 32 * col_d -: 32] ^ rdata;
    blk_in = cipher_mode ? {ctr_high, ctr_low} : data;
    n = (cnt > 5'd16) ? 5'd16 : cnt;
    for (int b = 0; b < 16; b++) begin
      mask[127 - 8 * b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    end
    ks = key_added;
    masked = ctr_blk ? ((ks ^ data) & mask) : ks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      rnd <= '0;
      col <= '0;
      first <= 1'b0;
      out_valid <= 1'b0;
      ctr_high <= '0;
      ctr_low <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (acc_in) begin
            data <= {s_tdata[63:0], s_tdata[127:64]};
            cnt <= s_tdata[132:128];
            ctr_blk <= cipher_mode;
            if (s_tdata[133]) begin
              ctr_high <= iv_high;
              ctr_low <= iv_low;
            end
          end
        end
        ST_EXPAND: idx <= idx + AW'(1);
        ST_LOAD: begin
          st <= blk_in;
          rnd <= '0;
          col <= '0;
          first <= 1'b1;
        end
        ST_ROUND: begin
          first <= 1'b0;
          rnd_d <= rnd;
          col_d <= col;
          if (!(rnd == nr && col == 2'd3)) begin
            col <= col + 2'd1;
            if (col == 2'd3) rnd <= rnd + 4'd1;
          end
          if (!first) begin
            acc <= key_added;
            if (col_d == 2'd3) st <= key_added;
          end
          if (rnd_d == nr && col_d == 2'd3 && !first) begin
            result <= masked;
            out_valid <= 1'b1;
            if (ctr_blk) begin
              {ctr_high, ctr_low} <= {ctr_high, ctr_low} + 128'd1;
            end
          end
        end
        ST_OUT: if (out_take) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  `AES_ASSERT_IMP(a_out_only_in_out, clk, rst, m_tvalid, state == ST_OUT,
    "result valid outside output state")
  `AES_ASSERT_IMP(a_no_accept_busy, clk, rst, s_tvalid && s_tready, state == ST_IDLE,
    "beat accepted while busy")
  `AES_ASSERT_NEXT(a_hold_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "result dropped under stall")

endmodule
